// ===== design/edge_shrinking_moving_average_macros.svh =====
// Assertion macros shared by the moving average block.
`ifndef EDGE_SHRINKING_MOVING_AVERAGE_MACROS_SVH
`define EDGE_SHRINKING_MOVING_AVERAGE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ESMA_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define ESMA_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/esma_pkg.sv =====
// Shared constants and types of the moving average block.
package esma_pkg;

  localparam int WINDOW_MAX  = 31;
  localparam int SAMPLE_BITS = 32;
  localparam int HIST_DEPTH  = 2 * WINDOW_MAX + 1;
  localparam int SEEN_MAX    = 4 * WINDOW_MAX + 3;

  localparam int WIN_W  = $clog2(WINDOW_MAX + 1);
  localparam int ADDR_W = $clog2(HIST_DEPTH);
  localparam int SEEN_W = $clog2(SEEN_MAX + 1);
  // Divisor 2w+1 never exceeds HIST_DEPTH.
  localparam int DIV_W  = $clog2(HIST_DEPTH + 1);
  localparam int ACC_W  = SAMPLE_BITS + ADDR_W;
  localparam int MAG_W  = ACC_W - 1;

  typedef struct packed {
    logic                    start;
    logic signed [ACC_W-1:0] dividend;
    logic [DIV_W-1:0]        divisor;
  } div_req_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] average;
    logic                          run_end;
  } res_t;

endpackage

// ===== design/esma_in_if.sv =====
// Input sample channel.
interface esma_in_if import esma_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          final_req;

  modport source (output valid, output sample, output final_req, input ready);
  modport sink (input valid, input sample, input final_req, output ready);
endinterface

// ===== design/esma_cfg_if.sv =====
// Configuration write channel for the half window register.
interface esma_cfg_if import esma_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [WIN_W-1:0] half_window;

  modport source (output valid, output half_window, input ready);
  modport sink (input valid, input half_window, output ready);
endinterface

// ===== design/esma_out_if.sv =====
// Smoothed result channel.
interface esma_out_if import esma_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] average;
  logic                          run_end;

  modport source (output valid, output average, output run_end, input ready);
  modport sink (input valid, input average, input run_end, output ready);
endinterface

// ===== design/esma_div.sv =====
// Serial restoring divider, one quotient bit per cycle, truncating toward zero.
module esma_div import esma_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  div_req_t                      req_i,
  output logic                          done_o,
  output logic signed [SAMPLE_BITS-1:0] quot_o
);

  localparam int CNT_W = $clog2(MAG_W + 1);

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             done_q, done_d;
  logic [DIV_W-1:0] rem_q, rem_d;
  logic [MAG_W-1:0] quo_q, quo_d;
  logic [DIV_W-1:0] dvs_q, dvs_d;
  logic             neg_q, neg_d;

  logic [DIV_W:0]   trial;
  logic [DIV_W:0]   diff;
  logic             ge;
  logic [ACC_W-1:0] mag;

  always_comb begin
    trial = {rem_q, quo_q[MAG_W-1]};
    ge    = trial >= {1'b0, dvs_q};
    diff  = trial - {1'b0, dvs_q};
    mag   = req_i.dividend[ACC_W-1] ? ACC_W'(-req_i.dividend) : ACC_W'(req_i.dividend);

    cnt_d  = cnt_q;
    done_d = 1'b0;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    neg_d  = neg_q;
    if (req_i.start) begin
      cnt_d = CNT_W'(MAG_W);
      rem_d = '0;
      quo_d = mag[MAG_W-1:0];
      dvs_d = req_i.divisor;
      neg_d = req_i.dividend[ACC_W-1];
    end else if (cnt_q != '0) begin
      cnt_d  = cnt_q - 1'b1;
      rem_d  = ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      quo_d  = {quo_q[MAG_W-2:0], ge};
      done_d = (cnt_q == CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
    neg_q <= neg_d;
  end

  assign done_o = done_q;
  assign quot_o = neg_q ? -quo_q[SAMPLE_BITS-1:0] : quo_q[SAMPLE_BITS-1:0];

endmodule

// ===== design/esma_seq.sv =====
// Sequencer: sample history, window planning, serial summing and divider control.
module esma_seq import esma_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [WIN_W-1:0]              cfg_win_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic                          final_i,
  output logic                          res_valid_o,
  input  logic                          res_ready_i,
  output res_t                          res_o,
  output div_req_t                      div_req_o,
  input  logic                          div_done_i,
  input  logic signed [SAMPLE_BITS-1:0] div_quot_i
);

  typedef enum logic [2:0] {
    S_IDLE, S_PLAN, S_LOAD, S_SUM, S_DIV, S_OUT
  } state_e;

  state_e            state_q;
  logic [WIN_W-1:0]  win_q;
  logic [SEEN_W-1:0] seen_q;
  logic [ADDR_W-1:0] wr_pos_q;
  logic [ADDR_W-1:0] base_q;
  logic              fin_q;
  logic [SEEN_W-1:0] n_q;
  logic [WIN_W-1:0]  r_q;
  logic [WIN_W-1:0]  ctr_q;
  logic [WIN_W-1:0]  w_q;
  logic              end_q;
  logic [DIV_W-1:0]  cnt_q;
  logic              rvld_q;

  logic [ADDR_W-1:0]             addr_q;
  logic [DIV_W-1:0]              len_q;
  logic signed [ACC_W-1:0]       acc_q;
  logic signed [SAMPLE_BITS-1:0] rdata_q;
  logic signed [SAMPLE_BITS-1:0] hist_mem_q [HIST_DEPTH];

  logic              in_acc;
  logic [WIN_W-1:0]  win_now;
  logic [SEEN_W-1:0] seen_inc;
  logic [SEEN_W-1:0] n_m1;
  logic [WIN_W-1:0]  rtop;
  logic              full_win;
  logic [SEEN_W-1:0] i_pos;
  logic [SEEN_W-1:0] nq_m1;
  logic              pend;
  logic [WIN_W-1:0]  w_rw;
  logic [WIN_W-1:0]  w_pl;
  logic [WIN_W-1:0]  back;
  logic [ADDR_W:0]   start_addr;
  logic              sum_done;

  always_comb begin
    in_acc   = in_valid_i && (state_q == S_IDLE);
    // The window is latched on the first sample of a series.
    if (seen_q == '0) begin
      win_now = (cfg_win_i > WIN_W'(WINDOW_MAX)) ? WIN_W'(WINDOW_MAX) : cfg_win_i;
    end else begin
      win_now = win_q;
    end
    seen_inc = (seen_q == SEEN_W'(SEEN_MAX)) ? seen_q : seen_q + 1'b1;
    n_m1     = seen_inc - 1'b1;
    rtop     = (SEEN_W'(win_now) < n_m1) ? win_now : n_m1[WIN_W-1:0];
    full_win = (SEEN_W + 1)'(seen_q) >= (SEEN_W + 1)'({win_now, 1'b0});

    // Flush planning for the output whose center lies r samples back.
    i_pos = n_q - 1'b1 - SEEN_W'(r_q);
    nq_m1 = n_q - 1'b1;
    pend  = (i_pos >= SEEN_W'(win_q)) || ({i_pos, 1'b0} >= {1'b0, nq_m1});
    w_rw  = (r_q < win_q) ? r_q : win_q;
    w_pl  = (i_pos < SEEN_W'(w_rw)) ? i_pos[WIN_W-1:0] : w_rw;

    // Newest end of the window sits ctr-w samples behind the newest sample.
    back = ctr_q - w_q;
    if (base_q >= ADDR_W'(back)) begin
      start_addr = (ADDR_W + 1)'(base_q) - (ADDR_W + 1)'(back);
    end else begin
      start_addr = (ADDR_W + 1)'(base_q) + (ADDR_W + 1)'(HIST_DEPTH) - (ADDR_W + 1)'(back);
    end

    sum_done = (state_q == S_SUM) && (cnt_q == '0) && !rvld_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      win_q    <= '0;
      seen_q   <= '0;
      wr_pos_q <= '0;
      fin_q    <= 1'b0;
      r_q      <= '0;
      end_q    <= 1'b0;
      cnt_q    <= '0;
      rvld_q   <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            win_q <= win_now;
            end_q <= 1'b0;
            fin_q <= final_i;
            if (final_i) begin
              seen_q   <= '0;
              wr_pos_q <= '0;
              r_q      <= rtop;
              state_q  <= S_PLAN;
            end else begin
              seen_q   <= seen_inc;
              wr_pos_q <= (wr_pos_q == ADDR_W'(HIST_DEPTH - 1)) ? '0 : wr_pos_q + 1'b1;
              if (full_win || !seen_q[0]) begin
                state_q <= S_LOAD;
              end
            end
          end
        end
        S_PLAN: begin
          if (pend) begin
            end_q   <= (r_q == '0);
            state_q <= S_LOAD;
          end else if (r_q == '0) begin
            state_q <= S_IDLE;
          end else begin
            r_q <= r_q - 1'b1;
          end
        end
        S_LOAD: begin
          cnt_q   <= DIV_W'({w_q, 1'b1});
          rvld_q  <= 1'b0;
          state_q <= S_SUM;
        end
        S_SUM: begin
          rvld_q <= (cnt_q != '0);
          if (cnt_q != '0) begin
            cnt_q <= cnt_q - 1'b1;
          end
          if (sum_done) begin
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done_i) begin
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (res_ready_i) begin
            if (fin_q && (r_q != '0)) begin
              r_q     <= r_q - 1'b1;
              state_q <= S_PLAN;
            end else begin
              state_q <= S_IDLE;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Window geometry, address walk and accumulator.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      base_q <= wr_pos_q;
      n_q    <= seen_inc;
      if (full_win) begin
        ctr_q <= win_now;
        w_q   <= win_now;
      end else begin
        ctr_q <= seen_q[WIN_W:1];
        w_q   <= seen_q[WIN_W:1];
      end
    end
    if ((state_q == S_PLAN) && pend) begin
      ctr_q <= r_q;
      w_q   <= w_pl;
    end
    if (state_q == S_LOAD) begin
      addr_q <= start_addr[ADDR_W-1:0];
      len_q  <= DIV_W'({w_q, 1'b1});
      acc_q  <= '0;
    end
    if (state_q == S_SUM) begin
      addr_q <= (addr_q == '0) ? ADDR_W'(HIST_DEPTH - 1) : addr_q - 1'b1;
      if (rvld_q) begin
        acc_q <= acc_q + ACC_W'(rdata_q);
      end
    end
  end

  // Sample history: one write per accepted sample, one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      hist_mem_q[wr_pos_q] <= sample_i;
    end
    rdata_q <= hist_mem_q[addr_q];
  end

  assign in_ready_o          = (state_q == S_IDLE);
  assign res_valid_o         = (state_q == S_OUT);
  assign res_o.average       = div_quot_i;
  assign res_o.run_end       = end_q;
  assign div_req_o.start     = sum_done;
  assign div_req_o.dividend  = acc_q;
  assign div_req_o.divisor   = len_q;

endmodule

// ===== design/edge_shrinking_moving_average.sv =====
// Centered moving average over signed Q16.16 samples whose window shrinks at
// both ends of a series. The half window is taken from the configuration
// register on the first sample of each series. A sample is taken only while
// the block is idle; a sample that yields no result frees the block on the
// next cycle. Each result is formed by reading and summing the window from
// the dual-port history memory, one sample at a time, then dividing the
// sum in the serial divider and handing the result over. The final sample
// of a series flushes up to w+1 results back to back, the last one marked
// with run_end. A finished result waits in an output register, so the next
// result is computed meanwhile.
module edge_shrinking_moving_average import esma_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  esma_in_if.sink  in_ch,
  esma_cfg_if.sink cfg_ch,
  esma_out_if.source out_ch
);

`include "edge_shrinking_moving_average_macros.svh"

  logic [WIN_W-1:0]              win_q;
  logic                          out_valid_q;
  logic signed [SAMPLE_BITS-1:0] out_avg_q;
  logic                          out_end_q;

  logic                          res_valid;
  logic                          res_ready;
  res_t                          res;
  div_req_t                      div_req;
  logic                          div_done;
  logic signed [SAMPLE_BITS-1:0] div_quot;

  esma_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_win_i   (win_q),
    .in_valid_i  (in_ch.valid),
    .in_ready_o  (in_ch.ready),
    .sample_i    (in_ch.sample),
    .final_i     (in_ch.final_req),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .div_req_o   (div_req),
    .div_done_i  (div_done),
    .div_quot_i  (div_quot)
  );

  esma_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  assign cfg_ch.ready = 1'b1;
  assign res_ready    = !out_valid_q || out_ch.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        win_q <= cfg_ch.half_window;
      end
      if (res_valid && res_ready) begin
        out_valid_q <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_avg_q <= res.average;
      out_end_q <= res.run_end;
    end
  end

  assign out_ch.valid   = out_valid_q;
  assign out_ch.average = out_avg_q;
  assign out_ch.run_end = out_end_q;

  // A result is only offered while the sequencer is busy with a sample.
  `ESMA_ASSERT_NOW(a_res_busy, clk_i, rst_ni, res_valid, !in_ch.ready, "result offered while idle")
  // A handed-over result always lands in the output register.
  `ESMA_ASSERT_NEXT(a_res_load, clk_i, rst_ni, res_valid && res_ready, out_valid_q, "result lost")
  // The last result of a series returns the block to idle.
  `ESMA_ASSERT_NEXT(a_end_idle, clk_i, rst_ni, res_valid && res_ready && res.run_end,
                    in_ch.ready, "not idle after series end")

endmodule

// ===== bench/tb_edge_shrinking_moving_average.sv =====
// Self-checking testbench for the edge-shrinking centered moving average.
module tb_edge_shrinking_moving_average;
  import esma_pkg::*;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          final_req;
  } sample_req_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  esma_in_if  in_ch ();
  esma_cfg_if cfg_ch ();
  esma_out_if out_ch ();

  edge_shrinking_moving_average dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_ch),
    .cfg_ch (cfg_ch),
    .out_ch (out_ch)
  );

  always #5 clk_i = ~clk_i;

  // Shadow of the block's series state.
  logic signed [SAMPLE_BITS-1:0] hist_mem [HIST_DEPTH];
  int unsigned cnt_seen;
  int unsigned wr_ptr;
  int unsigned win_latched;
  int unsigned win_reg;

  sample_req_t pending_reqs [$];
  res_t        expected_avgs [$];
  sample_req_t next_req;
  res_t        want_res;
  logic        in_fire;

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned errors;
  int unsigned samples_taken;
  int unsigned results_checked;
  int unsigned series_done;
  int unsigned window_writes;
  int unsigned rand_items;

  function automatic void note_error(string what);
    errors++;
    if (errors <= 10) $display("%s", what);
  endfunction

  // Mean of the 2w+1 samples centered ctr places behind the newest one.
  function automatic logic signed [SAMPLE_BITS-1:0] window_mean(int unsigned ctr,
                                                                int unsigned w);
    longint      acc;
    int unsigned d;
    int unsigned idx;
    acc = 0;
    for (d = ctr - w; d <= ctr + w; d++) begin
      idx = (wr_ptr + HIST_DEPTH - 1 - (d % HIST_DEPTH)) % HIST_DEPTH;
      acc += longint'(hist_mem[idx]);
    end
    acc = acc / longint'(2 * w + 1);
    return acc[SAMPLE_BITS-1:0];
  endfunction

  function automatic void push_avg(logic signed [SAMPLE_BITS-1:0] avg, logic last);
    res_t e;
    e.average = avg;
    e.run_end = last;
    expected_avgs.push_back(e);
  endfunction

  function automatic void take_sample(logic signed [SAMPLE_BITS-1:0] s, logic fin);
    int unsigned k;
    int unsigned wv;
    int unsigned n;
    int unsigned i;
    int unsigned w;
    int          r;
    int          rtop;
    if (cnt_seen == 0) win_latched = (win_reg > WINDOW_MAX) ? WINDOW_MAX : win_reg;
    wv = win_latched;
    k = cnt_seen;
    hist_mem[wr_ptr] = s;
    wr_ptr = (wr_ptr + 1) % HIST_DEPTH;
    if (cnt_seen < SEEN_MAX) cnt_seen++;
    if (!fin) begin
      if (k >= 2 * wv) push_avg(window_mean(wv, wv), 1'b0);
      else if (k % 2 == 0) push_avg(window_mean(k / 2, k / 2), 1'b0);
      return;
    end
    // The final sample flushes every pending output, oldest first.
    n = cnt_seen;
    rtop = (wv < n - 1) ? wv : n - 1;
    for (r = rtop; r >= 0; r--) begin
      i = n - 1 - r;
      if (i >= wv || 2 * i >= n - 1) begin
        w = wv;
        if (i < w) w = i;
        if (r < w) w = r;
        push_avg(window_mean(r, w), r == 0);
      end
    end
    cnt_seen = 0;
    wr_ptr = 0;
  endfunction

  // Driver of the sample channel.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_fire) begin
      if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_req = pending_reqs.pop_front();
        in_ch.valid     <= 1'b1;
        in_ch.sample    <= next_req.sample;
        in_ch.final_req <= next_req.final_req;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Monitor: predicts on every accepted request and checks every result.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_ch.valid && in_ch.ready;
      if (cfg_ch.valid && cfg_ch.ready) begin
        win_reg = cfg_ch.half_window;
        window_writes++;
      end
      if (in_ch.valid && in_ch.ready) begin
        take_sample(in_ch.sample, in_ch.final_req);
        samples_taken++;
        if (in_ch.final_req) series_done++;
      end
      if (out_ch.valid && out_ch.ready) begin
        results_checked++;
        if (expected_avgs.size() == 0) begin
          note_error($sformatf("Unexpected result: average %0d run_end %0b",
                               out_ch.average, out_ch.run_end));
        end else begin
          want_res = expected_avgs.pop_front();
          if (out_ch.average !== want_res.average)
            note_error($sformatf("Result %0d average: expected %0d, got %0d",
                                 results_checked, want_res.average, out_ch.average));
          if (out_ch.run_end !== want_res.run_end)
            note_error($sformatf("Result %0d run_end: expected %0b, got %0b",
                                 results_checked, want_res.run_end, out_ch.run_end));
        end
      end
    end
  end

  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(9))
      0: return 32'sh7fff_ffff;
      1: return 32'sh8000_0000;
      2: return $signed(32'($urandom_range(65535))) - 32'sd32768;
      default: return $signed($urandom);
    endcase
  endfunction

  task automatic push_req(logic signed [SAMPLE_BITS-1:0] s, logic fin);
    sample_req_t q;
    q.sample = s;
    q.final_req = fin;
    pending_reqs.push_back(q);
  endtask

  task automatic queue_samples(int unsigned len, bit ends_series);
    int unsigned j;
    for (j = 0; j < len; j++) push_req(pick_sample(), ends_series && (j == len - 1));
    rand_items += len;
  endtask

  // Hold off new requests until the block has delivered everything.
  task automatic drain();
    while (pending_reqs.size() != 0 || in_ch.valid) @(posedge clk_i);
    while (expected_avgs.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  task automatic write_half_window(logic [WIN_W-1:0] hw);
    @(negedge clk_i);
    cfg_ch.valid       <= 1'b1;
    cfg_ch.half_window <= hw;
    do @(posedge clk_i); while (!cfg_ch.ready);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic [WIN_W-1:0] pick_window();
    case ($urandom_range(5))
      0: return '0;
      1: return WIN_W'(WINDOW_MAX);
      default: return WIN_W'($urandom_range(WINDOW_MAX));
    endcase
  endfunction

  initial begin
    int unsigned nser;
    int unsigned s;
    int unsigned len;
    int unsigned cut;
    int unsigned wv;
    in_ch.valid        = 1'b0;
    in_ch.sample       = '0;
    in_ch.final_req    = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.half_window = '0;
    out_ch.ready       = 1'b0;
    rst_ni             = 1'b0;
    cnt_seen = 0;
    wr_ptr = 0;
    win_latched = 0;
    win_reg = 0;
    errors = 0;
    samples_taken = 0;
    results_checked = 0;
    series_done = 0;
    window_writes = 0;
    rand_items = 0;
    for (int j = 0; j < HIST_DEPTH; j++) hist_mem[j] = '0;
    send_idle_pct = 21;
    recv_idle_pct = 46;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: single-sample series and extremes with no averaging.
    push_req(32'sh7fff_ffff, 1'b1);
    push_req(32'sh8000_0000, 1'b0);
    push_req(32'sh7fff_ffff, 1'b0);
    push_req(32'sh0000_0000, 1'b1);
    drain();
    // Widest window on short series, so both ends shrink into each other.
    write_half_window(WIN_W'(WINDOW_MAX));
    push_req(32'sh8000_0000, 1'b0);
    push_req(32'sh8000_0000, 1'b0);
    push_req(32'sh8000_0000, 1'b1);
    push_req(-32'sd1, 1'b1);
    drain();
    // Mixed signs so that truncation toward zero shows on negative sums.
    write_half_window(WIN_W'(2));
    push_req(32'sh7fff_ffff, 1'b0);
    push_req(32'sh7fff_ffff, 1'b0);
    push_req(32'sh8000_0000, 1'b0);
    push_req(32'sd1, 1'b0);
    push_req(-32'sd1, 1'b0);
    push_req(-32'sd3, 1'b1);
    drain();
    // A window written mid-series must only apply to the next series.
    write_half_window(WIN_W'(1));
    push_req(-32'sd7, 1'b0);
    push_req(32'sd5, 1'b0);
    drain();
    write_half_window(WIN_W'(3));
    push_req(-32'sd2, 1'b0);
    push_req(32'sd9, 1'b1);
    push_req(-32'sd4, 1'b0);
    push_req(32'sd8, 1'b0);
    push_req(-32'sd11, 1'b1);
    drain();
    write_half_window('0);

    // Random series in groups of one to three, some with a window write mid-series.
    while (rand_items < 50) begin
      if (rand_items >= 34) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (rand_items >= 17) begin
        send_idle_pct = 46;
        recv_idle_pct = 21;
      end
      wv = pick_window();
      write_half_window(WIN_W'(wv));
      nser = $urandom_range(1, 3);
      for (s = 0; s < nser; s++) begin
        if ($urandom_range(7) == 0) len = 1;
        else if ($urandom_range(5) == 0) len = $urandom_range(2, 2 * wv + 4);
        else len = $urandom_range(2, (2 * wv + 4 < 24) ? 2 * wv + 4 : 24);
        if (len > 2 && $urandom_range(4) == 0) begin
          cut = $urandom_range(1, len - 1);
          queue_samples(cut, 1'b0);
          drain();
          write_half_window(pick_window());
          queue_samples(len - cut, 1'b1);
        end else begin
          queue_samples(len, 1'b1);
        end
      end
      drain();
    end

    // One series long enough to saturate the sample counter.
    write_half_window(WIN_W'($urandom_range(7)));
    queue_samples(130, 1'b1);
    drain();

    repeat (120) @(posedge clk_i);
    if (expected_avgs.size() != 0)
      note_error($sformatf("%0d expected results never arrived", expected_avgs.size()));
    $display("Checked %0d smoothed results from %0d samples in %0d series, %0d window writes.",
             results_checked, samples_taken, series_done, window_writes);
    $display("Covered windows 0 to 31, mid-series window change and counter saturation.");
    if (errors == 0) begin
      $display("** edge_shrinking_moving_average: PASSED **");
    end else begin
      $display("%0d mismatches in total.", errors);
      $display("** edge_shrinking_moving_average: FAILED **");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("Timeout with %0d results still expected.", expected_avgs.size());
    $display("** edge_shrinking_moving_average: FAILED **");
    $finish;
  end

endmodule
